@@ hw/rtl/lcm_pkg.sv @@
// ---------------------------------------------------------------------------
// lcm_pkg
// Shared constants and types of the Laplacian filter and max-pool core.
// ---------------------------------------------------------------------------
package lcm_pkg;

  localparam int MAX_SIZE    = 256;
  localparam int PIX_W       = 8;
  localparam int SIZE_W      = 9;
  localparam int COL_W       = $clog2(MAX_SIZE);
  localparam int SLOT_W      = COL_W - 1;
  localparam int POOL_DEPTH  = MAX_SIZE / 2;
  localparam int LINE_W      = 2 * PIX_W;
  localparam int VAL_W       = 12;
  localparam int OUT_TDATA_W = ((VAL_W + 7) / 8) * 8;
  localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;

  localparam logic [SIZE_W-1:0] MIN_SIDE   = SIZE_W'(4);
  localparam logic [SIZE_W-1:0] MAX_SIDE   = SIZE_W'(MAX_SIZE);
  localparam logic [COL_W-1:0]  RESET_LAST = COL_W'(7);

  // 3x3 window: [row][col], row 0 oldest line, col 2 newest pixel
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // per-item control that follows a pixel down the pipeline
  typedef struct packed {
    logic              valid;      // pixel sits inside the filtered map
    logic              pair_start; // even map column
    logic              row_store;  // odd map column of an even map row
    logic              emit;       // odd map column of an odd map row
    logic              last;       // final pixel of the image
    logic [SLOT_W-1:0] slot;
  } tag_t;

  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic signed [VAL_W-1:0] value;
  } res_t;

endpackage

@@ hw/rtl/lcm_ram.sv @@
// ---------------------------------------------------------------------------
// lcm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/lcm_window.sv @@
// ---------------------------------------------------------------------------
// lcm_window
// Raster counters, two-line store and the 3x3 pixel window.
// ---------------------------------------------------------------------------
module lcm_window (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       accept,
  input  logic [lcm_pkg::PIX_W-1:0]  pixel,
  input  logic                       cfg_wr,
  input  logic [lcm_pkg::SIZE_W-1:0] cfg_size,
  output lcm_pkg::tag_t              s2_tag,
  output lcm_pkg::win_t              win
);

  logic [lcm_pkg::COL_W-1:0]  col_r, row_r, last_r, last_nxt;
  logic [lcm_pkg::SIZE_W-1:0] eff;
  logic [lcm_pkg::COL_W-1:0]  col_m2;
  lcm_pkg::tag_t              tag_nxt, s1_tag_r, s2_tag_r;
  logic                       s1_vld_r;
  logic [lcm_pkg::PIX_W-1:0]  s1_px_r;
  logic [lcm_pkg::COL_W-1:0]  s1_col_r;
  logic [lcm_pkg::LINE_W-1:0] line_rd, line_wr;
  lcm_pkg::win_t              win_r;
  logic                       s1_go;

  // side length minus one, lowest bit dropped and clamped
  always_comb begin
    eff = cfg_size & ~lcm_pkg::SIZE_W'(1);
    if (eff < lcm_pkg::MIN_SIDE) begin
      last_nxt = lcm_pkg::COL_W'(3);
    end else if (eff > lcm_pkg::MAX_SIDE) begin
      last_nxt = lcm_pkg::COL_W'(lcm_pkg::MAX_SIZE - 1);
    end else begin
      last_nxt = lcm_pkg::COL_W'(eff - lcm_pkg::SIZE_W'(1));
    end
  end

  always_comb begin
    col_m2             = col_r - lcm_pkg::COL_W'(2);
    tag_nxt.valid      = accept && (row_r >= lcm_pkg::COL_W'(2)) &&
                         (col_r >= lcm_pkg::COL_W'(2));
    tag_nxt.pair_start = !col_r[0];
    tag_nxt.row_store  = col_r[0] && !row_r[0];
    tag_nxt.emit       = col_r[0] && row_r[0];
    tag_nxt.last       = (col_r == last_r) && (row_r == last_r);
    tag_nxt.slot       = col_m2[lcm_pkg::COL_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= lcm_pkg::RESET_LAST;
      col_r  <= '0;
      row_r  <= '0;
    end else if (cfg_wr) begin
      last_r <= last_nxt;
      col_r  <= '0;
      row_r  <= '0;
    end else if (accept) begin
      if (col_r == last_r) begin
        col_r <= '0;
        row_r <= (row_r == last_r) ? '0 : row_r + lcm_pkg::COL_W'(1);
      end else begin
        col_r <= col_r + lcm_pkg::COL_W'(1);
      end
    end
  end

  // word layout: low byte two rows up, high byte one row up
  lcm_ram #(
    .WIDTH (lcm_pkg::LINE_W),
    .DEPTH (lcm_pkg::MAX_SIZE)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data (line_wr),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (line_rd)
  );

  assign s1_go   = en && s1_vld_r;
  assign line_wr = {s1_px_r, line_rd[lcm_pkg::LINE_W-1:lcm_pkg::PIX_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_tag_r <= '0;
      s2_tag_r <= '0;
    end else if (en) begin
      s1_vld_r <= accept;
      s1_tag_r <= tag_nxt;
      s2_tag_r <= s1_vld_r ? s1_tag_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r  <= pixel;
      s1_col_r <= col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_go) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= line_rd[lcm_pkg::PIX_W-1:0];
      win_r[1][2] <= line_rd[lcm_pkg::LINE_W-1:lcm_pkg::PIX_W];
      win_r[2][2] <= s1_px_r;
    end
  end

  assign s2_tag = s2_tag_r;
  assign win    = win_r;

endmodule

@@ hw/rtl/lcm_pool.sv @@
// ---------------------------------------------------------------------------
// lcm_pool
// Laplacian response, horizontal pair maximum and pooled row store.
// ---------------------------------------------------------------------------
module lcm_pool (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  lcm_pkg::tag_t s2_tag,
  input  lcm_pkg::win_t win,
  output lcm_pkg::res_t res
);

  logic [lcm_pkg::VAL_W-2:0]       ring_sum;
  logic signed [lcm_pkg::VAL_W-1:0] lap;
  lcm_pkg::tag_t                    s3_tag_r;
  logic signed [lcm_pkg::VAL_W-1:0] s3_lap_r, pair_max_r, pm;
  logic signed [lcm_pkg::VAL_W-1:0] row_rd;
  logic [lcm_pkg::VAL_W-1:0]        row_rd_raw;

  // eight neighbours summed, centre times eight
  always_comb begin
    ring_sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1)) begin
          ring_sum = ring_sum + (lcm_pkg::VAL_W-1)'(win[r][c]);
        end
      end
    end
    lap = $signed({1'b0, win[1][1], 3'b000}) - $signed({1'b0, ring_sum});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_tag_r <= '0;
    end else if (en) begin
      s3_tag_r <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_lap_r <= lap;
    end
  end

  assign pm = (s3_tag_r.pair_start || pair_max_r < s3_lap_r) ? s3_lap_r : pair_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_max_r <= '0;
    end else if (en && s3_tag_r.valid) begin
      pair_max_r <= pm;
    end
  end

  lcm_ram #(
    .WIDTH (lcm_pkg::VAL_W),
    .DEPTH (lcm_pkg::POOL_DEPTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (en && s3_tag_r.valid && s3_tag_r.row_store),
    .wr_addr (s3_tag_r.slot),
    .wr_data (pm),
    .rd_en   (en && s2_tag.valid && s2_tag.emit),
    .rd_addr (s2_tag.slot),
    .rd_data (row_rd_raw)
  );

  assign row_rd = $signed(row_rd_raw);

  always_comb begin
    res.valid = s3_tag_r.valid && s3_tag_r.emit;
    res.last  = s3_tag_r.last;
    res.value = (row_rd > pm) ? row_rd : pm;
  end

endmodule

@@ hw/rtl/lcm_out_buf.sv @@
// ---------------------------------------------------------------------------
// lcm_out_buf
// Output register with a skid stage; its fill state stalls the pipeline.
// ---------------------------------------------------------------------------
module lcm_out_buf (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lcm_pkg::res_t                    res,
  output logic                             en,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lcm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);

  logic                             out_vld_r, skid_vld_r, take;
  logic signed [lcm_pkg::VAL_W-1:0] out_val_r, skid_val_r;
  logic                             out_last_r, skid_last_r;
  logic                             push;

  assign en   = !skid_vld_r;
  assign take = out_vld_r && out_tready;
  assign push = en && res.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      if (!out_vld_r || take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (take) begin
      out_vld_r  <= skid_vld_r;
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_vld_r || take) begin
        out_val_r  <= res.value;
        out_last_r <= res.last;
      end else begin
        skid_val_r  <= res.value;
        skid_last_r <= res.last;
      end
    end else if (take && skid_vld_r) begin
      out_val_r  <= skid_val_r;
      out_last_r <= skid_last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = lcm_pkg::OUT_TDATA_W'($unsigned(out_val_r));
  assign out_tlast  = out_last_r;

endmodule

@@ hw/rtl/laplacian_conv_maxpool_core.sv @@
// ---------------------------------------------------------------------------
// laplacian_conv_maxpool_core
// Streaming 3x3 Laplacian filter (valid region) followed by 2x2 max pooling.
// ---------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata[7:0] pixel
//  out_    | out | out_tvalid/out_tready| out_tdata[11:0] pooled_value, out_tlast
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data[8:0] image_size
//
// one pixel per clock while in_tready is high; the result of the pixel that
// completes a window passes through the line-store read, the window, the
// pooled-row read and the output register
// reset is synchronous; the line and row stores need no clearing pass
// in_tready drops only while the skid stage holds a result that the output
// register could not pass on; the whole pipeline then holds
// ---------------------------------------------------------------------------
module laplacian_conv_maxpool_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lcm_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] pixel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lcm_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [11:0] pooled_value
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lcm_pkg::SIZE_W-1:0]       cfg_data
);

  logic          en, accept;
  lcm_pkg::tag_t s2_tag;
  lcm_pkg::win_t win;
  lcm_pkg::res_t res;

  assign in_tready = en;
  assign accept    = in_tvalid && en;
  assign cfg_ready = 1'b1;

  lcm_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .accept   (accept),
    .pixel    (in_tdata[lcm_pkg::PIX_W-1:0]),
    .cfg_wr   (cfg_valid),
    .cfg_size (cfg_data),
    .s2_tag   (s2_tag),
    .win      (win)
  );

  lcm_pool u_pool (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .s2_tag (s2_tag),
    .win    (win),
    .res    (res)
  );

  lcm_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hw/rtl/lcm_checker.sv @@
// ---------------------------------------------------------------------------
// lcm_checker
// Port-level checks of the Laplacian max-pool core, bound to the top level.
// ---------------------------------------------------------------------------
module lcm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lcm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tlast
);

  // a result held back stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // with no result pending the skid is empty, so input must be open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[lcm_pkg::VAL_W-1:0]) >= -2040) &&
                   ($signed(out_tdata[lcm_pkg::VAL_W-1:0]) <= 2040))
    else $error("pooled value out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[lcm_pkg::OUT_TDATA_W-1:lcm_pkg::VAL_W] == '0)
    else $error("tdata padding not zero");

endmodule

bind laplacian_conv_maxpool_core lcm_checker u_lcm_checker (.*);

@@ dv/laplacian_conv_maxpool_core_tb.sv @@
// ---------------------------------------------------------------------------
// laplacian_conv_maxpool_core_tb
// Streams square images through the Laplacian and max-pool core and checks
// each pooled value and its end-of-image flag against an in-bench model,
// across several image sizes, with random idling on both streams.
// ---------------------------------------------------------------------------
module laplacian_conv_maxpool_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 5;
  localparam int PIPE_FLUSH  = 8;
  localparam int LONG_HOLD   = 300;
  localparam int WIDE_PART   = 40;
  localparam int RAND_ITEMS  = 160;

  typedef struct packed {
    logic                             last;
    logic signed [lcm_pkg::VAL_W-1:0] value;
  } pool_res_t;

  typedef enum logic {ROW_SIZE, ROW_PIXEL} row_kind_t;
  typedef enum logic [1:0] {MIX_UNIFORM, MIX_EXTREME, MIX_SPARSE} pix_mix_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [lcm_pkg::SIZE_W-1:0] data;   // size value or pixel
    logic                       known;  // expected result typed in below
    pool_res_t                  typed;
  } dir_row_t;

  localparam pool_res_t NO_RES = '0;

  // single bright pixel at (1,1) of a 4x4 image gives the top response
  localparam dir_row_t DIR_STEPS [21] = '{
    '{ROW_SIZE,  9'd5,   1'b0, NO_RES},  // lowest bit dropped, side 4
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd255, 1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b0, NO_RES},
    '{ROW_PIXEL, 9'd0,   1'b1, '{1'b1, 12'sd2040}},
    '{ROW_PIXEL, 9'd255, 1'b0, NO_RES},  // partial image, then abandoned
    '{ROW_PIXEL, 9'd170, 1'b0, NO_RES},
    '{ROW_PIXEL, 9'd85,  1'b0, NO_RES},
    '{ROW_SIZE,  9'd0,   1'b0, NO_RES}   // below the minimum, mid-image
  };

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [lcm_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lcm_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [lcm_pkg::SIZE_W-1:0]      cfg_data   = '0;

  // model state
  logic [lcm_pkg::SIZE_W-1:0]       size_reg;
  logic [lcm_pkg::PIX_W-1:0]        line_top [lcm_pkg::MAX_SIZE];
  logic [lcm_pkg::PIX_W-1:0]        line_mid [lcm_pkg::MAX_SIZE];
  logic [lcm_pkg::PIX_W-1:0]        win [3][3];
  int unsigned                      col_pos;
  int unsigned                      row_pos;
  logic signed [lcm_pkg::VAL_W-1:0] pooled_row [lcm_pkg::POOL_DEPTH];
  logic signed [lcm_pkg::VAL_W-1:0] pair_peak;

  pool_res_t   pooled_due [$];
  int unsigned pooled_total = 0;
  int unsigned bad_count    = 0;
  bit          idle_on      = 1'b1;
  int unsigned sink_hold    = 0;

  laplacian_conv_maxpool_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] pixel
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [11:0] pooled_value
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int unsigned side_of(logic [lcm_pkg::SIZE_W-1:0] size_val);
    int unsigned n;
    n = 32'({size_val[lcm_pkg::SIZE_W-1:1], 1'b0});
    if (n < 4) n = 4;
    else if (n > lcm_pkg::MAX_SIZE) n = lcm_pkg::MAX_SIZE;
    return n;
  endfunction

  function automatic logic [lcm_pkg::PIX_W-1:0] pick_pixel(pix_mix_t mix);
    case (mix)
      MIX_EXTREME: return $urandom_range(0, 1) ? lcm_pkg::PIX_W'(2**lcm_pkg::PIX_W - 1)
                                               : lcm_pkg::PIX_W'(0);
      MIX_SPARSE: begin
        if ($urandom_range(0, 7) == 0) return lcm_pkg::PIX_W'($urandom_range(128, 255));
        return lcm_pkg::PIX_W'($urandom_range(0, 8));
      end
      default: return lcm_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // one pixel through the filter and the pooling stage
  task automatic laplace_pool(input logic [lcm_pkg::PIX_W-1:0] px, output bit got,
                              output pool_res_t res);
    int unsigned                      n, c, r, j, slot;
    logic [lcm_pkg::PIX_W-1:0]        top, mid;
    int                               sum;
    logic signed [lcm_pkg::VAL_W-1:0] resp;
    n   = side_of(size_reg);
    got = 1'b0;
    res = '0;
    if (col_pos >= n) col_pos = 0;
    if (row_pos >= n) row_pos = 0;
    c = col_pos;
    r = row_pos;
    top = line_top[c];
    mid = line_mid[c];
    line_top[c] = mid;
    line_mid[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    if (r >= 2 && c >= 2) begin
      j    = c - 2;
      slot = (j >> 1) % lcm_pkg::POOL_DEPTH;
      sum  = 0;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          sum += (a == 1 && b == 1) ? 8 * int'(win[a][b]) : -int'(win[a][b]);
      resp = lcm_pkg::VAL_W'(sum);
      if ((j & 1) == 0) begin
        pair_peak = resp;
      end else begin
        if (resp > pair_peak) pair_peak = resp;
        if (((r - 2) & 1) == 0) begin
          pooled_row[slot] = pair_peak;
        end else begin
          got       = 1'b1;
          res.value = (pooled_row[slot] > pair_peak) ? pooled_row[slot] : pair_peak;
          res.last  = (r == n - 1 && c == n - 1);
        end
      end
    end
    col_pos = c + 1;
    if (col_pos >= n) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= n) row_pos = 0;
    end
  endtask

  task automatic send_pixel(input logic [lcm_pkg::PIX_W-1:0] px, input logic known = 1'b0,
                            input pool_res_t typed = '0);
    bit        got;
    pool_res_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= lcm_pkg::IN_TDATA_W'(px);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    laplace_pool(px, got, res);
    if (known) begin
      pooled_due.push_back(typed);
      pooled_total++;
    end else if (got) begin
      pooled_due.push_back(res);
      pooled_total++;
    end
  endtask

  // size writes only once the core has drained
  task automatic write_size(input logic [lcm_pkg::SIZE_W-1:0] size_val);
    in_tvalid <= 1'b0;
    while (pooled_due.size() != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_reg  = size_val;
    col_pos   = 0;
    row_pos   = 0;
    pair_peak = '0;
  endtask

  task automatic flag_error(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("%t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_pooled
    pool_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pooled_due.size() == 0) begin
        flag_error($sformatf("unexpected result %0d last %0b",
                             $signed(out_tdata[lcm_pkg::VAL_W-1:0]), out_tlast));
      end else begin
        want = pooled_due.pop_front();
        if (out_tdata[lcm_pkg::VAL_W-1:0] !== want.value || out_tlast !== want.last)
          flag_error($sformatf("expected %0d last %0b, got %0d last %0b",
                               $signed(want.value), want.last,
                               $signed(out_tdata[lcm_pkg::VAL_W-1:0]), out_tlast));
      end
    end
  end

  initial begin : sink
    wait (rst_n);
    forever begin
      if (sink_hold != 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned                n, count, base_items;
    pix_mix_t                   mix;
    logic [lcm_pkg::SIZE_W-1:0] size_val;
    size_reg  = lcm_pkg::SIZE_W'(8);
    col_pos   = 0;
    row_pos   = 0;
    pair_peak = '0;
    foreach (line_top[i]) begin
      line_top[i] = '0;
      line_mid[i] = '0;
    end
    foreach (pooled_row[i]) pooled_row[i] = '0;
    foreach (win[a, b]) win[a][b] = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // one whole image at the size left by reset
    n = side_of(size_reg);
    for (int k = 0; k < n * n; k++) send_pixel(pick_pixel(MIX_UNIFORM));

    foreach (DIR_STEPS[i]) begin
      if (DIR_STEPS[i].kind == ROW_SIZE)
        write_size(DIR_STEPS[i].data);
      else
        send_pixel(DIR_STEPS[i].data[lcm_pkg::PIX_W-1:0], DIR_STEPS[i].known,
                   DIR_STEPS[i].typed);
    end

    // oversized setting clamps to the widest image; part of its first row
    write_size(lcm_pkg::SIZE_W'(2**lcm_pkg::SIZE_W - 1));
    for (int k = 0; k < WIDE_PART; k++) send_pixel(pick_pixel(MIX_UNIFORM));

    // the sink stalls for a long stretch from the start of the third row, before the first pooled value
    size_val = lcm_pkg::SIZE_W'(8);
    n        = side_of(size_val);
    write_size(size_val);
    for (int k = 0; k < n * n; k++) begin
      if (k == 2 * n) sink_hold = LONG_HOLD;
      send_pixel(pick_pixel(MIX_UNIFORM));
    end

    // small images back to back, some cut short by the next size write
    base_items = 0;
    while (base_items < RAND_ITEMS) begin
      size_val = lcm_pkg::SIZE_W'($urandom_range(0, 9));
      n        = side_of(size_val);
      mix      = pix_mix_t'($urandom_range(0, 2));
      idle_on  = ($urandom_range(0, 3) != 0);
      count    = $urandom_range(1, 2) * n * n + $urandom_range(0, n * n / 2);
      write_size(size_val);
      for (int k = 0; k < count; k++) send_pixel(pick_pixel(mix));
      base_items += count;
    end

    // closing stretch at full rate on both sides
    idle_on  = 1'b0;
    size_val = lcm_pkg::SIZE_W'($urandom_range(4, 8));
    n        = side_of(size_val);
    write_size(size_val);
    for (int k = 0; k < 2 * n * n; k++) send_pixel(pick_pixel(MIX_UNIFORM));
    in_tvalid <= 1'b0;

    while (pooled_due.size() != 0) @(posedge clk);
    repeat (4 * PIPE_FLUSH) @(posedge clk);
    if (bad_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
